/* rtl/compact_target_codec_core_assert.svh */
// ----------------------------------------------------------------------------
// Compact target codec assertion macros
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMPACT_TARGET_CODEC_CORE_ASSERT_SVH
`define COMPACT_TARGET_CODEC_CORE_ASSERT_SVH

// Checked at every edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// Checked only while reset is released.
`define CTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

/* rtl/cmpt_pkg.sv */
// ----------------------------------------------------------------------------
// Compact target codec package
// Shared widths, request codes, stage records and the bit scan helper.
// ----------------------------------------------------------------------------
package cmpt_pkg;

  localparam int unsigned ValW     = 256;
  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned CmpW     = 32;
  localparam int unsigned MantW    = 23;
  localparam int unsigned DataW    = 288;
  localparam int unsigned UserW    = 2;

  // Decode overflow limits on the size byte
  localparam logic [7:0] SizeLimAny  = 8'd34;
  localparam logic [7:0] SizeLimByte = 8'd33;
  localparam logic [7:0] SizeLimHalf = 8'd32;
  localparam logic [7:0] SizeSmall   = 8'd3;
  localparam logic [7:0] SizeGone    = 8'd35;
  localparam logic [MantW-1:0] MantByteMax = 23'h0000ff;
  localparam logic [MantW-1:0] MantHalfMax = 23'h00ffff;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_e;

  typedef struct packed {
    logic [MantW-1:0] mant;  // mantissa after small-size shift
    logic [4:0]       sh;    // byte shift left
    logic             zero;  // shifted beyond 256 bits
    logic             neg;
    logic             ovf;
  } dec_t;

  typedef struct packed {
    req_e                       req;
    logic                       neg;
    logic [ValW-1:0]            value;
    logic [NumWords-1:0]        word_nz;
    logic [NumWords-1:0][5:0]   word_top;
    dec_t                       dec;
  } scan_t;

  typedef struct packed {
    req_e            req;
    logic            neg;
    logic [ValW-1:0] value;
    logic [5:0]      size;
    dec_t            dec;
  } sized_t;

  // Position of the highest set bit of a 64-bit word (0 when empty)
  function automatic logic [5:0] top_bit64(input logic [WordW-1:0] w);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < WordW; i++) begin
      if (w[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* rtl/cmpt_scan.sv */
// ----------------------------------------------------------------------------
// Compact target codec scan stage
// Finds the top bit of each value word and prepares the decode mantissa.
// ----------------------------------------------------------------------------
module cmpt_scan
  import cmpt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  req_e            req_i,
  input  logic            neg_i,
  input  logic [ValW-1:0] value_i,
  input  logic [CmpW-1:0] compact_i,
  output logic            valid_o,
  input  logic            ready_i,
  output scan_t           scan_o
);

  logic  valid_q;
  scan_t scan_q, scan_d;

  logic [7:0]       size8;
  logic [MantW-1:0] mant_raw;
  logic [MantW-1:0] mant_sh;
  logic             mant_nz;

  assign size8    = compact_i[31:24];
  assign mant_raw = compact_i[MantW-1:0];

  always_comb begin
    if (size8 <= SizeSmall) begin
      mant_sh = mant_raw >> {2'(2'd3 - size8[1:0]), 3'b000};
    end else begin
      mant_sh = mant_raw;
    end
  end

  assign mant_nz = |mant_sh;

  always_comb begin
    scan_d.req   = req_i;
    scan_d.neg   = neg_i;
    scan_d.value = value_i;
    for (int i = 0; i < NumWords; i++) begin
      scan_d.word_nz[i]  = |value_i[i*WordW +: WordW];
      scan_d.word_top[i] = top_bit64(value_i[i*WordW +: WordW]);
    end
    scan_d.dec.mant = mant_sh;
    scan_d.dec.sh   = (size8 > SizeSmall) ? 5'(size8 - SizeSmall) : 5'd0;
    scan_d.dec.zero = size8 >= SizeGone;
    scan_d.dec.neg  = mant_nz && compact_i[MantW];
    scan_d.dec.ovf  = mant_nz && ((size8 > SizeLimAny) ||
                                  ((mant_sh > MantByteMax) && (size8 > SizeLimByte)) ||
                                  ((mant_sh > MantHalfMax) && (size8 > SizeLimHalf)));
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign scan_o  = scan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      scan_q <= scan_d;
    end
  end

endmodule

/* rtl/cmpt_size.sv */
// ----------------------------------------------------------------------------
// Compact target codec size stage
// Turns the per-word top bits into the byte length of the value.
// ----------------------------------------------------------------------------
module cmpt_size
  import cmpt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  scan_t  scan_i,
  output logic   valid_o,
  input  logic   ready_i,
  output sized_t sized_o
);

  logic   valid_q;
  sized_t sized_q, sized_d;

  logic [1:0] top_idx;
  logic [5:0] top_pos;
  logic       any_nz;
  logic [8:0] bit_len;
  logic [8:0] len_round;

  // Highest nonzero word wins
  always_comb begin
    top_idx = '0;
    top_pos = '0;
    any_nz  = 1'b0;
    for (int i = 0; i < NumWords; i++) begin
      if (scan_i.word_nz[i]) begin
        top_idx = 2'(i);
        top_pos = scan_i.word_top[i];
        any_nz  = 1'b1;
      end
    end
  end

  assign bit_len   = any_nz ? ({1'b0, top_idx, top_pos} + 9'd1) : 9'd0;
  assign len_round = bit_len + 9'd7;

  always_comb begin
    sized_d.req   = scan_i.req;
    sized_d.neg   = scan_i.neg;
    sized_d.value = scan_i.value;
    sized_d.size  = len_round[8:3];
    sized_d.dec   = scan_i.dec;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign sized_o = sized_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sized_q <= sized_d;
    end
  end

endmodule

/* rtl/cmpt_align.sv */
// ----------------------------------------------------------------------------
// Compact target codec align stage
// Byte-aligns the mantissa in either direction and holds the output beat.
// ----------------------------------------------------------------------------
module cmpt_align
  import cmpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  sized_t           sized_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] data_o,
  output logic [UserW-1:0] user_o
);

  logic             valid_q;
  logic [DataW-1:0] data_q, data_d;
  logic [UserW-1:0] user_q, user_d;

  logic [ValW+23:0] val_ext;
  logic [23:0]      mant24;
  logic [22:0]      enc_mant;
  logic [5:0]       enc_size;
  logic             enc_sign;
  logic [CmpW-1:0]  enc_word;
  logic [ValW-1:0]  dec_val;

  // Top three bytes of the value, zero filled below byte zero
  assign val_ext = {sized_i.value, 24'd0};
  assign mant24  = val_ext[{sized_i.size, 3'b000} +: 24];

  always_comb begin
    if (mant24[23]) begin
      enc_mant = {7'd0, mant24[23:8]};
      enc_size = sized_i.size + 6'd1;
    end else begin
      enc_mant = mant24[22:0];
      enc_size = sized_i.size;
    end
  end

  assign enc_sign = sized_i.neg && (|enc_mant);
  assign enc_word = {2'b00, enc_size, enc_sign, enc_mant};

  assign dec_val = sized_i.dec.zero ? '0 :
                   ({{(ValW-MantW){1'b0}}, sized_i.dec.mant} << {sized_i.dec.sh, 3'b000});

  always_comb begin
    if (sized_i.req == REQ_DECODE) begin
      data_d = {dec_val, {CmpW{1'b0}}};
      user_d = {sized_i.dec.ovf, sized_i.dec.neg};
    end else begin
      data_d = {{ValW{1'b0}}, enc_word};
      user_d = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

endmodule

/* rtl/compact_target_codec_core.sv */
// ----------------------------------------------------------------------------
// Compact target codec core
// Converts a 256-bit value to the 32-bit compact form and back, one beat
// per cycle while m_axis is not stalled, through a three-stage pipeline.
//
//   channel  dir  tdata                                  tuser
//   s_axis   in   value_w0..w3, compact_in               req_type, negative_in
//   m_axis   out  compact_out, result_w0..w3             negative_out, overflow_out
//
// Each beat is registered in the scan, size and align stages in turn; a new
// beat can enter before the earlier ones have left the pipeline.
// Reset clears only the stage valid bits; data registers load on a beat.
// A stall on m_axis backs up through the stage valid bits, and a beat is
// accepted as long as any stage ahead can make room.
// ----------------------------------------------------------------------------
module compact_target_codec_core
  import cmpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // value_w0, value_w1, value_w2, value_w3, compact_in
  input  logic [UserW-1:0] s_axis_tuser_i,   // req_type, negative_in
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // compact_out, result_w0, result_w1, result_w2,
                                             // result_w3
  output logic [UserW-1:0] m_axis_tuser_o    // negative_out, overflow_out
);

  logic   scan_valid, scan_ready;
  scan_t  scan;
  logic   size_valid, size_ready;
  sized_t sized;
  req_e   req;

  assign req = req_e'(s_axis_tuser_i[0]);

  cmpt_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .req_i     (req),
    .neg_i     (s_axis_tuser_i[1]),
    .value_i   (s_axis_tdata_i[ValW-1:0]),
    .compact_i (s_axis_tdata_i[ValW +: CmpW]),
    .valid_o   (scan_valid),
    .ready_i   (scan_ready),
    .scan_o    (scan)
  );

  cmpt_size u_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_valid),
    .ready_o (scan_ready),
    .scan_i  (scan),
    .valid_o (size_valid),
    .ready_i (size_ready),
    .sized_o (sized)
  );

  cmpt_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (size_valid),
    .ready_o (size_ready),
    .sized_i (sized),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (m_axis_tdata_o),
    .user_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/cmpt_chk.sv */
// ----------------------------------------------------------------------------
// Compact target codec port checker
// Watches the core's stream ports for reset, stall and latency behavior.
// ----------------------------------------------------------------------------
`include "compact_target_codec_core_assert.svh"

module cmpt_chk
  import cmpt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [DataW-1:0] m_axis_tdata_o,
  input logic [UserW-1:0] m_axis_tuser_o
);

  logic s_beat;

  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;

  property p_hold_stalled;
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
      $stable(m_axis_tuser_o);
  endproperty

  property p_stall_only_full;
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i;
  endproperty

  property p_latency;
    $past(s_beat, 3) && $past(m_axis_tready_i, 2) && $past(m_axis_tready_i, 1) &&
      $past(rst_ni, 2) && $past(rst_ni, 1) |-> m_axis_tvalid_o;
  endproperty

  `CTC_ASSERT_ALWAYS(a_rst_no_beat, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")

  `CTC_ASSERT(a_hold_stalled, p_hold_stalled, "stalled output beat changed")

  `CTC_ASSERT(a_stall_only_full, p_stall_only_full, "input stalled without output backpressure")

  `CTC_ASSERT(a_latency, p_latency, "beat missing after three cycles")

endmodule

bind compact_target_codec_core cmpt_chk u_chk (.*);

/* tb/compact_target_codec_check.sv */
// ----------------------------------------------------------------------------
// Compact target codec checker
// Watches both stream channels, predicts the conversion for every accepted
// input beat and compares each output beat, field by field, in order.
// ----------------------------------------------------------------------------
module compact_target_codec_check
  import cmpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [DataW-1:0] s_axis_tdata_i,   // value_w0, value_w1, value_w2, value_w3, compact_in
  input  logic [UserW-1:0] s_axis_tuser_i,   // req_type, negative_in
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [DataW-1:0] m_axis_tdata_i,   // compact_out, result_w0, result_w1, result_w2,
                                             // result_w3
  input  logic [UserW-1:0] m_axis_tuser_i,   // negative_out, overflow_out
  output int               err_cnt_o,
  output int unsigned      pending_o
);

  localparam logic [31:0] SignFlag = 32'h0080_0000;
  localparam logic [31:0] MantMask = 32'h007f_ffff;
  localparam logic [31:0] Mant24   = 32'h00ff_ffff;
  localparam int unsigned MaxShown = 10;

  typedef struct packed {
    logic [CmpW-1:0] cmp;
    logic [ValW-1:0] val;
    logic            neg;
    logic            ovf;
  } conv_res_t;

  conv_res_t conv_q[$];
  int        mism_cnt = 0;

  function automatic conv_res_t convert(input req_e rq, input logic [ValW-1:0] v,
                                        input logic ng, input logic [CmpW-1:0] cw);
    conv_res_t   res;
    int unsigned blen;
    int unsigned size;
    int unsigned shift;
    logic [31:0] mant;
    res  = '0;
    blen = 0;
    if (rq == REQ_ENCODE) begin
      for (int i = 0; i < ValW; i++) begin
        if (v[i]) begin
          blen = i + 1;
        end
      end
      size = (blen + 7) / 8;
      if (size <= 3) begin
        mant = v[31:0] << (8 * (3 - size));
      end else begin
        mant = 32'(v >> (8 * (size - 3))) & Mant24;
      end
      // keep the mantissa positive: move one byte into the size
      if (mant & SignFlag) begin
        mant = mant >> 8;
        size = size + 1;
      end
      mant    = mant & MantMask;
      res.cmp = mant | (32'(size[7:0]) << 24);
      if (ng && mant != 0) begin
        res.cmp = res.cmp | SignFlag;
      end
    end else begin
      size = cw[31:24];
      mant = cw & MantMask;
      if (size <= 3) begin
        mant    = mant >> (8 * (3 - size));
        res.val = ValW'(mant);
      end else begin
        shift = 8 * (size - 3);
        if (shift < ValW) begin
          res.val = ValW'(mant) << shift;
        end
      end
      res.neg = (mant != 0) && ((cw & SignFlag) != 0);
      res.ovf = (mant != 0) && (size > 34 || (mant > 32'hff && size > 33) ||
                                (mant > 32'hffff && size > 32));
    end
    return res;
  endfunction

  task automatic report(input string what, input logic [ValW-1:0] want,
                        input logic [ValW-1:0] got);
    mism_cnt++;
    if (mism_cnt <= MaxShown) begin
      $display("mismatch on %s: expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    conv_res_t got;
    conv_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.cmp = m_axis_tdata_i[31:0];
        got.val = m_axis_tdata_i[CmpW +: ValW];
        got.neg = m_axis_tuser_i[0];
        got.ovf = m_axis_tuser_i[1];
        if (conv_q.size() == 0) begin
          report("beat with nothing pending", '0, got.val);
        end else begin
          want = conv_q.pop_front();
          if (got.cmp !== want.cmp) begin
            report("compact_out", ValW'(want.cmp), ValW'(got.cmp));
          end
          for (int k = 0; k < NumWords; k++) begin
            if (got.val[WordW*k +: WordW] !== want.val[WordW*k +: WordW]) begin
              report($sformatf("result_w%0d", k), ValW'(want.val[WordW*k +: WordW]),
                     ValW'(got.val[WordW*k +: WordW]));
            end
          end
          if (got.neg !== want.neg) begin
            report("negative_out", ValW'(want.neg), ValW'(got.neg));
          end
          if (got.ovf !== want.ovf) begin
            report("overflow_out", ValW'(want.ovf), ValW'(got.ovf));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        conv_q.push_back(convert(req_e'(s_axis_tuser_i[0]), s_axis_tdata_i[ValW-1:0],
                                 s_axis_tuser_i[1], s_axis_tdata_i[ValW +: CmpW]));
      end
    end
    err_cnt_o <= mism_cnt;
    pending_o <= conv_q.size();
  end

endmodule

/* tb/compact_target_codec_core_test.sv */
// ----------------------------------------------------------------------------
// Compact target codec testbench
// Drives encode and decode beats (directed corner values, then random ones)
// through several idle and stall mixes; the checker grades every output beat.
// ----------------------------------------------------------------------------
module compact_target_codec_core_test;
  import cmpt_pkg::*;

  localparam int unsigned ItemsPerPhase = 250;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned DrainCycles   = 20;

  logic             clk_i;
  logic             rst_ni;
  logic             s_valid;
  logic             s_ready;
  logic [DataW-1:0] s_tdata;
  logic [UserW-1:0] s_tuser;
  logic             m_valid;
  logic             m_ready;
  logic [DataW-1:0] m_tdata;
  logic [UserW-1:0] m_tuser;
  int               err_cnt;
  int unsigned      pending;
  int unsigned      src_idle_pct;
  int unsigned      sink_stall_pct;

  int unsigned idle_mix  [NumPhases] = '{0, 54, 0, 14};
  int unsigned stall_mix [NumPhases] = '{0, 0, 54, 14};

  compact_target_codec_core i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  compact_target_codec_check i_check (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: stall at random per the current mix
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Value with a random bit length, biased toward short ones
  function automatic logic [ValW-1:0] rand_value();
    logic [ValW-1:0] v;
    int unsigned     len;
    int unsigned     kind;
    for (int i = 0; i < ValW / 32; i++) begin
      v[32*i +: 32] = $urandom();
    end
    kind = $urandom_range(9);
    if (kind == 0) begin
      len = 0;
    end else if (kind < 4) begin
      len = $urandom_range(32, 1);
    end else begin
      len = $urandom_range(ValW, 1);
    end
    if (len == 0) begin
      v = '0;
    end else begin
      if (len < ValW) begin
        v = v & ((ValW'(1) << len) - 1);
      end
      v[len-1] = 1'b1;
    end
    return v;
  endfunction

  // Compact word with sizes clustered around the small and overflow edges
  function automatic logic [CmpW-1:0] rand_compact();
    logic [7:0]  size;
    logic [22:0] mant;
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      size = 8'($urandom_range(255));
    end else if (kind < 5) begin
      size = 8'($urandom_range(36, 30));
    end else begin
      size = 8'($urandom_range(40));
    end
    kind = $urandom_range(9);
    case (kind)
      0: begin
        mant = '0;
      end
      1: begin
        mant = 23'($urandom_range(32'hff));
      end
      2: begin
        mant = 23'($urandom_range(32'hffff));
      end
      default: begin
        mant = 23'($urandom());
      end
    endcase
    return {size, 1'($urandom_range(1)), mant};
  endfunction

  // Present one beat and hold it until accepted
  task automatic drive_beat(input req_e rq, input logic [ValW-1:0] v, input logic ng,
                            input logic [CmpW-1:0] cw);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_tdata = {cw, v};
    s_tuser = {ng, rq};
    @(posedge clk_i);
    while (!s_ready) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_ni         = 1'b0;
    s_valid        = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // encode corners: zero, tiny, mantissa high bit, full width
    drive_beat(REQ_ENCODE, '0, 1'b0, '0);
    drive_beat(REQ_ENCODE, '0, 1'b1, '1);
    drive_beat(REQ_ENCODE, 256'h1, 1'b1, '0);
    drive_beat(REQ_ENCODE, 256'h80, 1'b0, '0);
    drive_beat(REQ_ENCODE, 256'h7f_ffff, 1'b1, '0);
    drive_beat(REQ_ENCODE, 256'h80_0000, 1'b1, '0);
    drive_beat(REQ_ENCODE, 256'h1234_5600, 1'b0, '0);
    drive_beat(REQ_ENCODE, {1'b1, 255'b0}, 1'b1, '0);
    drive_beat(REQ_ENCODE, '1, 1'b1, '1);
    drive_beat(REQ_ENCODE, {8'h7f, 248'b0}, 1'b0, '0);
    // decode corners: small sizes, overflow edges, sign on empty mantissa
    drive_beat(REQ_DECODE, '1, 1'b1, 32'h0000_0000);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h00ff_ffff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h0112_3456);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h0292_3456);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h03ff_ffff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h0480_0000);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h2200_00ff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h2300_0001);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h2100_0100);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h2000_ffff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h2001_0000);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'h1d7f_ffff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'hff7f_ffff);
    drive_beat(REQ_DECODE, '0, 1'b0, 32'hffff_ffff);

    for (int p = 0; p < NumPhases; p++) begin
      src_idle_pct   = idle_mix[p];
      sink_stall_pct = stall_mix[p];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        drive_beat(req_e'($urandom_range(1)), rand_value(), 1'($urandom_range(1)),
                   rand_compact());
      end
    end
    @(negedge clk_i);
    s_valid = 1'b0;

    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
